### src/point_in_polygon_classifier_core_assert.svh
// Assertion macros for the point-in-polygon classifier.
// Used by the checker module; depends on nothing else.
`ifndef POINT_IN_POLYGON_CLASSIFIER_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PIPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point_in_polygon_classifier_core: assertion failed");

// Next-cycle implication, disabled during reset.
`define PIPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point_in_polygon_classifier_core: assertion failed");

`endif

### src/pipc_pkg.sv
// Types and constants shared by the point-in-polygon classifier.
// No dependencies.
package pipc_pkg;

  localparam int COORD_W = 31;
  localparam int DIFF_W = 32;
  localparam int PROD_W = 64;
  localparam int SUM_W = 65;
  localparam int CFG_W = 11;
  localparam int INDEX_W = 10;
  localparam int MIN_VERTICES = 3;
  localparam int MUL_STEPS = 6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam diff_t CORNER = 32'sd1000000001;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    VERDICT_INSIDE = 2'd0,
    VERDICT_OUTSIDE = 2'd1,
    VERDICT_BOUNDARY = 2'd2
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_LD_LAST,
    ST_RD,
    ST_LD,
    ST_MUL,
    ST_FIN,
    ST_EVAL,
    ST_DONE
  } pipc_state_t;

  // True when (ax, ay) is at or after (bx, by) in x-then-y order.
  function automatic logic lex_ge(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    return (ax > bx) || ((ax == bx) && (ay >= by));
  endfunction

endpackage

### src/pipc_item_if.sv
// Handshake interfaces for input items and results.
// Depends on pipc_pkg.
interface pipc_item_if;
  import pipc_pkg::*;
  logic valid;
  logic ready;
  cmd_t cmd;
  logic [INDEX_W-1:0] vertex_index;
  coord_t coord_x;
  coord_t coord_y;
  modport source (output valid, cmd, vertex_index, coord_x, coord_y, input ready);
  modport sink (input valid, cmd, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pipc_result_if;
  import pipc_pkg::*;
  logic valid;
  logic ready;
  verdict_t verdict;
  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

### src/pipc_vertex_mem.sv
// Vertex store: one write port, one registered read port.
// Depends on pipc_pkg.
module pipc_vertex_mem #(
  parameter int DEPTH = 1024,
  localparam int AddrW = $clog2(DEPTH)
) (
  input logic clk,
  input logic we,
  input logic [AddrW-1:0] waddr,
  input pipc_pkg::vertex_t wdata,
  input logic re,
  input logic [AddrW-1:0] raddr,
  output pipc_pkg::vertex_t rdata
);
  import pipc_pkg::*;

  vertex_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/pipc_mul.sv
// Shared signed 32 x 32 multiplier with a registered product.
// Depends on pipc_pkg.
module pipc_mul (
  input logic clk,
  input pipc_pkg::diff_t op_a,
  input pipc_pkg::diff_t op_b,
  output pipc_pkg::prod_t prod
);
  import pipc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

### src/point_in_polygon_classifier_core.sv
// Point-in-polygon classifier. Each edge of a query passes through the single
// shared multiplier six times, plus a memory read and an evaluate step.
// Depends on pipc_pkg, the interfaces, pipc_vertex_mem and pipc_mul.
module point_in_polygon_classifier_core #(
  parameter int MAX_VERTICES = 1024
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [pipc_pkg::CFG_W-1:0] cfg_wdata,
  pipc_item_if.sink item,
  pipc_result_if.source result
);
  import pipc_pkg::*;

  localparam int AddrW = $clog2(MAX_VERTICES);
  localparam int CntW = $clog2(MAX_VERTICES + 1);
  localparam coord_t CornerPt = COORD_W'(CORNER);

  pipc_state_t state, state_next;
  logic [CntW-1:0] vertex_count, cfg_sat, idx, cnt_m1;
  logic [2:0] step;
  coord_t qx, qy, ax, ay, bx, by;
  diff_t rx, ry, ex, ey, dx, dy, op_a, op_b;
  prod_t prods [MUL_STEPS];
  prod_t mul_p;
  logic boundary, parity, last_edge, done_load, mem_re, rd_last;
  logic accept, mem_we;
  vertex_t mem_wdata, mem_rdata;
  logic [AddrW-1:0] mem_raddr, mem_waddr;
  logic result_valid;
  verdict_t verdict;
  sum_t h1, l1, h2, l2;
  logic edge_bnd, edge_cross, on_ray, on_edge, par, a_on, b_on, a_le_b, q_le_c;

  always_comb begin
    if (cfg_wdata < CFG_W'(MIN_VERTICES)) begin
      cfg_sat = CntW'(MIN_VERTICES);
    end else if (32'(cfg_wdata) > MAX_VERTICES) begin
      cfg_sat = CntW'(MAX_VERTICES);
    end else begin
      cfg_sat = CntW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CntW'(MIN_VERTICES);
    end else if (cfg_we) begin
      vertex_count <= cfg_sat;
    end
  end

  assign accept = item.valid && item.ready;
  assign mem_we = accept && (item.cmd == CMD_WRITE) && (32'(item.vertex_index) < MAX_VERTICES);
  assign mem_waddr = AddrW'(item.vertex_index);
  assign mem_wdata = '{x: item.coord_x, y: item.coord_y};
  assign cnt_m1 = vertex_count - CntW'(1);
  assign mem_raddr = rd_last ? cnt_m1[AddrW-1:0] : idx[AddrW-1:0];
  assign last_edge = (idx + CntW'(1)) == vertex_count;

  pipc_vertex_mem #(.DEPTH(MAX_VERTICES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  always_comb begin
    case (step)
      3'd0: begin op_a = ex; op_b = dy; end
      3'd1: begin op_a = dx; op_b = ey; end
      3'd2: begin op_a = ex; op_b = ry; end
      3'd3: begin op_a = rx; op_b = ey; end
      3'd4: begin op_a = dy; op_b = rx; end
      default: begin op_a = dx; op_b = ry; end
    endcase
  end

  pipc_mul u_mul (.clk(clk), .op_a(op_a), .op_b(op_b), .prod(mul_p));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    mem_re = 1'b0;
    rd_last = 1'b0;
    done_load = 1'b0;
    case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid && (item.cmd == CMD_QUERY)) begin
          state_next = ST_RD_LAST;
        end
      end
      ST_RD_LAST: begin
        mem_re = 1'b1;
        rd_last = 1'b1;
        state_next = ST_LD_LAST;
      end
      ST_LD_LAST: state_next = ST_RD;
      ST_RD: begin
        mem_re = 1'b1;
        state_next = ST_LD;
      end
      ST_LD: state_next = ST_MUL;
      ST_MUL: begin
        if (step == 3'(MUL_STEPS - 1)) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: state_next = ST_EVAL;
      ST_EVAL: state_next = last_edge ? ST_DONE : ST_RD;
      ST_DONE: begin
        if (!result_valid || result.ready) begin
          done_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Edge evaluation from the six products of the current edge.
  always_comb begin
    h1 = SUM_W'(prods[1]) - SUM_W'(prods[0]);
    l1 = SUM_W'(prods[3]) - SUM_W'(prods[2]);
    h2 = SUM_W'(prods[4]) - SUM_W'(prods[5]);
    l2 = SUM_W'(prods[2]) - SUM_W'(prods[3]);
    par = prods[2] == prods[3];
    a_le_b = lex_ge(bx, by, ax, ay);
    q_le_c = lex_ge(CornerPt, CornerPt, qx, qy);
    edge_bnd = (prods[0] == prods[1]) &&
               (a_le_b ? (lex_ge(qx, qy, ax, ay) && lex_ge(bx, by, qx, qy))
                       : (lex_ge(qx, qy, bx, by) && lex_ge(ax, ay, qx, qy)));
    on_ray = (l1 > 0) ? (h1 >= 0 && h1 <= l1) : (h1 <= 0 && h1 >= l1);
    on_edge = (l2 > 0) ? (h2 > 0 && h2 < l2) : (h2 < 0 && h2 > l2);
    a_on = (prods[4] == prods[5]) &&
           (q_le_c ? (lex_ge(ax, ay, qx, qy) && lex_ge(CornerPt, CornerPt, ax, ay))
                   : (lex_ge(ax, ay, CornerPt, CornerPt) && lex_ge(qx, qy, ax, ay)));
    b_on = ((SUM_W'(prods[4]) + SUM_W'(prods[3])) == (SUM_W'(prods[5]) + SUM_W'(prods[2])))
           && (q_le_c ? (lex_ge(bx, by, qx, qy) && lex_ge(CornerPt, CornerPt, bx, by))
                      : (lex_ge(bx, by, CornerPt, CornerPt) && lex_ge(qx, qy, bx, by)));
    if ((bx > by) && a_on) begin
      on_edge = 1'b1;
    end
    if ((ax > ay) && b_on) begin
      on_edge = 1'b1;
    end
    edge_cross = !par && on_ray && on_edge;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        qx <= item.coord_x;
        qy <= item.coord_y;
        rx <= CORNER - DIFF_W'(item.coord_x);
        ry <= CORNER - DIFF_W'(item.coord_y);
        idx <= '0;
        boundary <= 1'b0;
        parity <= 1'b0;
      end
      ST_LD_LAST: begin
        ax <= mem_rdata.x;
        ay <= mem_rdata.y;
      end
      ST_LD: begin
        bx <= mem_rdata.x;
        by <= mem_rdata.y;
        ex <= DIFF_W'(mem_rdata.x) - DIFF_W'(ax);
        ey <= DIFF_W'(mem_rdata.y) - DIFF_W'(ay);
        dx <= DIFF_W'(ax) - DIFF_W'(qx);
        dy <= DIFF_W'(ay) - DIFF_W'(qy);
        step <= '0;
      end
      ST_MUL: begin
        step <= step + 3'd1;
        if (step != 3'd0) begin
          prods <= {prods[1:MUL_STEPS-1], mul_p};
        end
      end
      ST_FIN: prods <= {prods[1:MUL_STEPS-1], mul_p};
      ST_EVAL: begin
        boundary <= boundary | edge_bnd;
        parity <= parity ^ edge_cross;
        ax <= bx;
        ay <= by;
        dx <= DIFF_W'(bx) - DIFF_W'(qx);
        dy <= DIFF_W'(by) - DIFF_W'(qy);
        idx <= idx + CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done_load) begin
      result_valid <= 1'b1;
    end else if (result.ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_load) begin
      verdict <= boundary ? VERDICT_BOUNDARY : (parity ? VERDICT_INSIDE : VERDICT_OUTSIDE);
    end
  end

  assign result.valid = result_valid;
  assign result.verdict = verdict;

endmodule

### src/pipc_checker.sv
// Port-level checks for the point-in-polygon classifier and their binding.
// Depends on pipc_pkg and the assertion macro header.
`include "point_in_polygon_classifier_core_assert.svh"

module pipc_checker (
  input logic clk,
  input logic rst,
  input logic item_valid,
  input logic item_ready,
  input pipc_pkg::cmd_t item_cmd,
  input logic result_valid,
  input logic result_ready,
  input pipc_pkg::verdict_t result_verdict
);
  import pipc_pkg::*;

  `PIPC_ASSERT_NEXT(query_blocks_input, clk, rst, item_valid && item_ready && item_cmd == CMD_QUERY, !item_ready)
  `PIPC_ASSERT_NEXT(write_keeps_ready, clk, rst, item_valid && item_ready && item_cmd == CMD_WRITE, item_ready)
  `PIPC_ASSERT_NOW(result_after_busy, clk, rst, $rose(result_valid), !$past(item_ready))
  `PIPC_ASSERT_NEXT(result_holds, clk, rst, result_valid && !result_ready, result_valid && $stable(result_verdict))

endmodule

bind point_in_polygon_classifier_core pipc_checker u_pipc_checker (
  .clk(clk),
  .rst(rst),
  .item_valid(item.valid),
  .item_ready(item.ready),
  .item_cmd(item.cmd),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .result_verdict(result.verdict)
);
